// ===== rtl/ray_rectangle_closest_hit_core_defines.svh =====
// ============================================================================
// Assertion macros for the rectangle closest-hit core
// Shared property shapes used by the core's concurrent checks.
// ============================================================================
`ifndef RAY_RECTANGLE_CLOSEST_HIT_CORE_DEFINES_SVH
`define RAY_RECTANGLE_CLOSEST_HIT_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define RRC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked on the following clock edge.
`define RRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rrc_pkg.sv =====
// ============================================================================
// rrc_pkg
// Types and constants shared by the rectangle closest-hit core.
// ============================================================================
package rrc_pkg;

  localparam int Entries      = 64;
  localparam int IdxW         = $clog2(Entries);
  localparam int FracBits     = 16;
  localparam int PosW         = 14;
  localparam int SizeW        = 15;
  localparam int EntryW       = 3 * PosW + 3 * SizeW + 2 + 1;

  localparam logic [1:0] ModeWrite = 2'd0;
  localparam logic [1:0] ModeQuery = 2'd1;
  localparam logic [1:0] ModeClear = 2'd2;

  localparam logic [0:0] CfgTileScale   = 1'b0;
  localparam logic [0:0] CfgHeightScale = 1'b1;

  // Query sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_SCALE,
    ST_OFFSET,
    ST_DIV,
    ST_KCHK,
    ST_MUL,
    ST_TEST,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [PosW-1:0]  px, py, pz;
    logic signed [SizeW-1:0] sx, sy, sz;
    logic [1:0]              axis;
    logic                    coll;
  } entry_t;

  // Divider request and response.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

endpackage

// ===== rtl/rrc_div.sv =====
// ============================================================================
// rrc_div
// Unsigned 64-bit restoring divider, one quotient bit per cycle.
// ============================================================================
module rrc_div
  import rrc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [63:0] quo_r, quo_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;

  // One shift-subtract step per cycle.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[63]} - {1'b0, den_r};
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[62:0], quo_r[63]};
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// ===== rtl/ray_rectangle_closest_hit_core.sv =====
// ============================================================================
// ray_rectangle_closest_hit_core
// Table of axis-aligned rectangles with an iterative closest-hit ray query.
// ============================================================================
// Usage: drive in_* with start high while busy is low to hand over one beat.
// Mode 0 writes one table entry, mode 2 invalidates all entries; neither
// raises busy or produces a result. Mode 1 casts a ray: the sequencer
// walks the 64 entries in index order and tests each valid colliding
// candidate: it scales its geometry, runs the shared bit-serial divider
// and then computes the hit point with one multiplier, one axis at a time,
// dropping the candidate as soon as a check fails. At the end out_valid
// is high for exactly one cycle with the result beat; the receiver cannot
// stall it. busy stays high for the whole query.
// cfg_* writes the tile and height scales; write them only while idle.
// Reset clears all valid bits, the scales to 1.0 and the sequencer to idle.
// ============================================================================
`include "ray_rectangle_closest_hit_core_defines.svh"
module ray_rectangle_closest_hit_core
  import rrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [30:0]        cfg_wdata,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [5:0]         in_index,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  input  logic [1:0]         in_normal_axis,
  input  logic               in_collides,
  input  logic [30:0]        in_limit,
  input  logic [6:0]         in_exclude,
  output logic               out_valid,
  output logic               out_hit,
  output logic [5:0]         out_hit_index,
  output logic signed [31:0] out_hit_k,
  output logic signed [31:0] out_hit_x,
  output logic signed [31:0] out_hit_y,
  output logic signed [31:0] out_hit_z
);

  localparam logic signed [63:0] One = 64'sd1 <<< FracBits;

  logic [30:0] tile_r, height_r;
  logic [Entries-1:0] valid_r;
  entry_t mem [Entries];
  entry_t ent_r;

  state_t state_r, state_nxt;
  logic [IdxW:0] idx_r;
  logic [IdxW-1:0] cur;
  logic signed [63:0] o_r [3];
  logic signed [63:0] v_r [3];
  logic signed [63:0] wp_r [3];
  logic signed [63:0] ws_r [3];
  logic signed [63:0] pt_r [3];
  logic [1:0] sub_r;
  logic signed [63:0] low_r, bk_r;
  logic [6:0] excl_r;
  logic found_r;
  logic [IdxW-1:0] bidx_r;
  logic signed [63:0] bpt_r [3];
  logic signed [63:0] p1, p2, d;
  logic [63:0] mp1, mp2, k_r, t;
  logic neg;
  logic signed [63:0] biased;
  logic in_rect;
  logic skip;
  div_req_t dreq;
  div_rsp_t drsp;
  logic mul_sel;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [SizeW-1:0] sz_a;
  logic signed [47:0] sz_p;
  logic signed [63:0] mag_v;
  logic query_go;

  assign cur = idx_r[IdxW-1:0];
  assign busy = (state_r != ST_IDLE);
  assign query_go = start && !busy && (in_mode == ModeQuery);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_r   <= 31'd65536;
      height_r <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgTileScale:   tile_r   <= cfg_wdata;
        CfgHeightScale: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Entry memory with registered read.
  always_ff @(posedge clk) begin
    if (start && !busy && in_mode == ModeWrite) begin
      mem[in_index] <= '{px: in_a_x[PosW-1:0], py: in_a_y[PosW-1:0],
                         pz: in_a_z[PosW-1:0], sx: in_b_x[SizeW-1:0],
                         sy: in_b_y[SizeW-1:0], sz: in_b_z[SizeW-1:0],
                         axis: in_normal_axis, coll: in_collides};
    end
    ent_r <= mem[cur];
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (start && !busy && in_mode == ModeWrite) begin
      valid_r[in_index] <= 1'b1;
    end else if (start && !busy && in_mode == ModeClear) begin
      valid_r <= '0;
    end
  end

  // Shared multiplier: scaling, then hit-point terms. The size term reuses
  // the same scale operand through a narrow side product.
  always_comb begin
    mul_p = mul_a * mul_b;
    sz_p  = sz_a * mul_b;
  end

  assign p1  = v_r[ent_r.axis];
  assign mp1 = p1[63] ? 64'(-p1) : 64'(p1);
  assign p2  = wp_r[ent_r.axis] - o_r[ent_r.axis];
  assign mp2 = p2[63] ? 64'(-p2) : 64'(p2);
  assign neg = (ws_r[0] > 0) ^ (ws_r[1] < 0) ^ (ws_r[2] > 0) ^ p1[63];
  assign biased = neg ? $signed(k_r) - One : $signed(k_r) + One;
  assign skip = ({1'b0, cur} == excl_r) || !valid_r[cur] || !ent_r.coll ||
                (ent_r.axis == 2'd3);

  assign dreq.start = (state_r == ST_OFFSET) && !(p2 != 0 && (p2[63] != p1[63]));
  assign dreq.num   = mp2 << FracBits;
  assign dreq.den   = mp1;

  rrc_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (dreq),
    .rsp (drsp)
  );

  // Operand select: k times the direction magnitude when computing the hit
  // point (k fits in 31 bits there), grid value times scale otherwise.
  always_comb begin
    mag_v = v_r[sub_r];
    mag_v = mag_v[63] ? -mag_v : mag_v;
    mul_sel = (state_r == ST_MUL);
    if (mul_sel) begin
      mul_a = mag_v[32:0];
      mul_b = $signed({2'b00, k_r[30:0]});
      sz_a  = '0;
    end else begin
      mul_a = (sub_r == 2'd0) ? 33'(ent_r.px) : (sub_r == 2'd1) ? 33'(ent_r.py)
            : 33'(ent_r.pz);
      mul_b = (sub_r == 2'd1) ? $signed({2'b00, height_r})
            : $signed({1'b0, tile_r, 1'b0});
      sz_a  = (sub_r == 2'd0) ? ent_r.sx : (sub_r == 2'd1) ? ent_r.sy : ent_r.sz;
    end
    t = 64'(mul_p) >> FracBits;
  end

  // Bounds test of the hit point over the three axes.
  always_comb begin
    in_rect = 1'b1;
    d = '0;
    for (int a = 0; a < 3; a++) begin
      d = pt_r[a] - wp_r[a];
      if (ws_r[a] > 0) in_rect = in_rect && (d < ws_r[a]) && (d >= 0);
      else if (ws_r[a] < 0) in_rect = in_rect && (d > ws_r[a]) && (d <= 0);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (query_go) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_SCALE;
      ST_SCALE: begin
        if (skip || mp1 * 64'd1000 <= 64'(One)) begin
          state_nxt = (idx_r == (IdxW+1)'(Entries-1)) ? ST_DONE : ST_READ;
        end else if (sub_r == 2'd2) begin
          state_nxt = ST_OFFSET;
        end
      end
      ST_OFFSET: state_nxt = dreq.start ? ST_DIV :
                   ((idx_r == (IdxW+1)'(Entries-1)) ? ST_DONE : ST_READ);
      ST_DIV:    if (drsp.done) state_nxt = ST_KCHK;
      ST_KCHK:   state_nxt = ($signed(k_r) > low_r || k_r > 64'h7fff_ffff_ffff) ?
                   ((idx_r == (IdxW+1)'(Entries-1)) ? ST_DONE : ST_READ) : ST_MUL;
      ST_MUL:    if (sub_r == 2'd2) state_nxt = ST_TEST;
      ST_TEST:   state_nxt = (idx_r == (IdxW+1)'(Entries-1)) ? ST_DONE : ST_READ;
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      sub_r   <= '0;
      found_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          idx_r   <= '0;
          sub_r   <= '0;
          found_r <= 1'b0;
        end
        ST_SCALE: begin
          if (skip || mp1 * 64'd1000 <= 64'(One)) begin
            idx_r <= idx_r + 1'b1;
            sub_r <= '0;
          end else begin
            sub_r <= (sub_r == 2'd2) ? 2'd0 : sub_r + 2'd1;
          end
        end
        ST_OFFSET: if (!dreq.start) idx_r <= idx_r + 1'b1;
        ST_KCHK:   if ($signed(k_r) > low_r || k_r > 64'h7fff_ffff_ffff)
                     idx_r <= idx_r + 1'b1;
        ST_MUL:    sub_r <= (sub_r == 2'd2) ? 2'd0 : sub_r + 2'd1;
        ST_TEST: begin
          idx_r <= idx_r + 1'b1;
          if (in_rect && biased < low_r) found_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (query_go) begin
      o_r[0] <= 64'(in_a_x); o_r[1] <= 64'(in_a_y); o_r[2] <= 64'(in_a_z);
      v_r[0] <= 64'(in_b_x); v_r[1] <= 64'(in_b_y); v_r[2] <= 64'(in_b_z);
      low_r  <= $signed({33'd0, in_limit});
      excl_r <= in_exclude;
      bk_r   <= '0;
      bidx_r <= '0;
      for (int a = 0; a < 3; a++) bpt_r[a] <= '0;
    end
    if (state_r == ST_SCALE) begin
      wp_r[sub_r] <= 64'(mul_p);
      ws_r[sub_r] <= 64'(sz_p);
    end
    if (drsp.done) k_r <= drsp.quo;
    if (state_r == ST_MUL)
      pt_r[sub_r] <= o_r[sub_r] + (v_r[sub_r][63] ? -$signed(t) : $signed(t));
    if (state_r == ST_TEST && in_rect && biased < low_r) begin
      low_r  <= biased;
      bk_r   <= biased;
      bidx_r <= cur;
      for (int a = 0; a < 3; a++) bpt_r[a] <= pt_r[a];
    end
  end

  // Result beat.
  assign out_valid     = (state_r == ST_DONE);
  assign out_hit       = found_r;
  assign out_hit_index = bidx_r;
  assign out_hit_k     = bk_r[31:0];
  assign out_hit_x     = bpt_r[0][31:0];
  assign out_hit_y     = bpt_r[1][31:0];
  assign out_hit_z     = bpt_r[2][31:0];

  `RRC_ASSERT_NEXT(a_done_idle, state_r == ST_DONE, state_r == ST_IDLE, "done not followed by idle")
  `RRC_ASSERT_IMP(a_div_in_div, drsp.busy, state_r == ST_DIV, "divider busy outside divide state")
  `RRC_ASSERT_NEXT(a_start_busy, query_go, busy, "query accepted but not busy")
  `RRC_ASSERT_IMP(a_no_hit_zero, out_valid && !out_hit, out_hit_k == 0, "no hit with nonzero k")

endmodule

// ===== tb/ray_rectangle_closest_hit_core_tb.sv =====
// ============================================================================
// Closest-hit core testbench
// Writes rectangle tables, clears them and casts rays under several scale
// settings. Every result beat is checked field by field against a predictor
// that models the table, the scales and the closest-hit walk.
// ============================================================================
module ray_rectangle_closest_hit_core_tb;
  import rrc_pkg::*;

  localparam longint CycleLimit = 20_000_000;
  localparam longint One = 64'sd1 <<< FracBits;

  typedef struct {
    logic [1:0]         mode;
    logic [5:0]         index;
    logic signed [31:0] a [3];
    logic signed [31:0] b [3];
    logic [1:0]         axis;
    logic               coll;
    logic [30:0]        limit;
    logic [6:0]         excl;
  } ray_cmd_t;

  typedef struct {
    logic               hit;
    logic [5:0]         idx;
    logic signed [31:0] k;
    logic signed [31:0] pt [3];
  } hit_rec_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [0:0]         cfg_index = CfgTileScale;
  logic [30:0]        cfg_wdata = '0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_mode = ModeWrite;
  logic [5:0]         in_index = '0;
  logic signed [31:0] in_a_x = '0, in_a_y = '0, in_a_z = '0;
  logic signed [31:0] in_b_x = '0, in_b_y = '0, in_b_z = '0;
  logic [1:0]         in_normal_axis = '0;
  logic               in_collides = 1'b0;
  logic [30:0]        in_limit = '0;
  logic [6:0]         in_exclude = '0;
  logic               out_valid;
  logic               out_hit;
  logic [5:0]         out_hit_index;
  logic signed [31:0] out_hit_k, out_hit_x, out_hit_y, out_hit_z;

  ray_rectangle_closest_hit_core u_dut (.*);

  // Model of the table and scales.
  longint   tbl_pos [Entries][3];
  longint   tbl_size [Entries][3];
  int       tbl_axis [Entries];
  bit       tbl_coll [Entries];
  bit       tbl_valid [Entries];
  longint   tile_scale_m = 65536;
  longint   height_scale_m = 65536;

  ray_cmd_t pending_cmds[$];
  hit_rec_t expected_hits[$];
  int       errors = 0;
  int       queries_done = 0;
  int       hits_seen = 0;
  longint   cycles = 0;

  initial forever #10 clk = ~clk;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d (query %0d)", what, got, want, queries_done);
    errors++;
  endtask

  function automatic longint to_world(longint g, int ax);
    return (ax == 1) ? g * height_scale_m : g * tile_scale_m * 2;
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Closest-hit walk over the modeled table.
  function automatic hit_rec_t cast_ray(ray_cmd_t c);
    hit_rec_t res;
    longint o [3], v [3], pp [3], ss [3], pt [3];
    longint lowest, p1, p2, mp1, mp2, q, r, k, biased, t, dv, d;
    bit neg, in_rect;
    int ax;
    res.hit = 1'b0; res.idx = '0; res.k = '0;
    for (int a = 0; a < 3; a++) res.pt[a] = '0;
    lowest = longint'(c.limit);
    for (int a = 0; a < 3; a++) begin
      o[a] = longint'(c.a[a]);
      v[a] = longint'(c.b[a]);
    end
    for (int e = 0; e < Entries; e++) begin
      ax = tbl_axis[e];
      if (e == int'(c.excl) || !tbl_valid[e] || !tbl_coll[e] || ax > 2) continue;
      p1 = v[ax];
      mp1 = mag(p1);
      if (mp1 * 1000 <= One) continue;
      for (int a = 0; a < 3; a++) begin
        pp[a] = to_world(tbl_pos[e][a], a);
        ss[a] = to_world(tbl_size[e][a], a);
      end
      p2 = pp[ax] - o[ax];
      if (p2 != 0 && ((p2 < 0) != (p1 < 0))) continue;
      mp2 = mag(p2);
      q = mp2 / mp1;
      if (q > 64'h7fffffff) continue;
      r = mp2 % mp1;
      k = (q << FracBits) + ((r << FracBits) / mp1);
      if (k > lowest) continue;
      neg = (ss[0] > 0) ^ (ss[1] < 0) ^ (ss[2] > 0) ^ (p1 < 0);
      biased = neg ? k - One : k + One;
      in_rect = 1'b1;
      for (int a = 0; a < 3; a++) begin
        t = (mag(v[a]) * k) >> FracBits;
        dv = (v[a] < 0) ? -t : t;
        pt[a] = o[a] + dv;
        d = pt[a] - pp[a];
        if (ss[a] > 0) in_rect = in_rect && d < ss[a] && d >= 0;
        else if (ss[a] < 0) in_rect = in_rect && d > ss[a] && d <= 0;
      end
      if (in_rect && biased < lowest) begin
        lowest = biased;
        res.hit = 1'b1;
        res.idx = e[5:0];
        res.k = biased[31:0];
        for (int a = 0; a < 3; a++) res.pt[a] = pt[a][31:0];
      end
    end
    return res;
  endfunction

  // Apply one accepted beat to the model.
  task automatic take_cmd(ray_cmd_t c);
    logic signed [13:0] p14;
    logic signed [14:0] s15;
    case (c.mode)
      ModeWrite: begin
        for (int a = 0; a < 3; a++) begin
          p14 = c.a[a][13:0];
          s15 = c.b[a][14:0];
          tbl_pos[c.index][a] = longint'(p14);
          tbl_size[c.index][a] = longint'(s15);
        end
        tbl_axis[c.index] = int'(c.axis);
        tbl_coll[c.index] = c.coll;
        tbl_valid[c.index] = 1'b1;
      end
      ModeClear: for (int e = 0; e < Entries; e++) tbl_valid[e] = 1'b0;
      ModeQuery: expected_hits.push_back(cast_ray(c));
      default: ;
    endcase
  endtask

  function automatic ray_cmd_t blank_cmd(logic [1:0] m);
    ray_cmd_t c;
    c.mode = m; c.index = '0; c.axis = '0; c.coll = 1'b0;
    c.limit = 31'h7fffffff; c.excl = 7'd64;
    for (int a = 0; a < 3; a++) begin c.a[a] = '0; c.b[a] = '0; end
    return c;
  endfunction

  function automatic ray_cmd_t rect_cmd(int idx, int px, int py, int pz,
                                        int sx, int sy, int sz, int ax, bit cl);
    ray_cmd_t c;
    c = blank_cmd(ModeWrite);
    c.index = idx[5:0]; c.axis = ax[1:0]; c.coll = cl;
    c.a[0] = px; c.a[1] = py; c.a[2] = pz;
    c.b[0] = sx; c.b[1] = sy; c.b[2] = sz;
    return c;
  endfunction

  function automatic ray_cmd_t ray_cmd(int ox, int oy, int oz, int dx, int dy, int dz,
                                       logic [30:0] lim, int ex);
    ray_cmd_t c;
    c = blank_cmd(ModeQuery);
    c.a[0] = ox; c.a[1] = oy; c.a[2] = oz;
    c.b[0] = dx; c.b[1] = dy; c.b[2] = dz;
    c.limit = lim; c.excl = ex[6:0];
    return c;
  endfunction

  function automatic int rnd_range(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Random beat: mostly small, well-formed geometry, some full-range noise.
  function automatic ray_cmd_t random_cmd();
    ray_cmd_t c;
    int sel;
    bit noisy;
    sel = rnd_range(0, 99);
    noisy = ($urandom_range(0, 9) == 0);
    if (sel < 42) begin
      c = blank_cmd(ModeWrite);
      c.index = 6'($urandom_range(0, 63));
      c.axis = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      c.coll = ($urandom_range(0, 7) != 0);
      for (int a = 0; a < 3; a++) begin
        c.a[a] = noisy ? $urandom() : rnd_range(-12, 12);
        c.b[a] = noisy ? $urandom() : rnd_range(-6, 6);
      end
    end else if (sel < 90) begin
      c = blank_cmd(ModeQuery);
      for (int a = 0; a < 3; a++) begin
        c.a[a] = noisy ? $urandom() : rnd_range(-30, 30) * 32768 + rnd_range(-40000, 40000);
        case ($urandom_range(0, 7))
          0: c.b[a] = 0;
          1: c.b[a] = rnd_range(-70, 70);
          2: c.b[a] = $urandom();
          default: c.b[a] = rnd_range(-196608, 196608);
        endcase
      end
      c.limit = ($urandom_range(0, 2) == 0) ? 31'($urandom()) : 31'h7fffffff;
      c.excl = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) : 7'd64;
    end else if (sel < 98) begin
      c = blank_cmd(ModeClear);
    end else begin
      c = blank_cmd(2'd3);
    end
    if (noisy) begin
      c.index = 6'($urandom()); c.limit = 31'($urandom()); c.excl = 7'($urandom());
    end
    return c;
  endfunction

  // Driver: bursts of beats with random gaps between them.
  int burst_left = 0;
  int gap_left = 0;
  ray_cmd_t next_cmd;
  bit drive_now;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        take_cmd(pending_cmds.pop_front());
        burst_left--;
      end
      if (burst_left <= 0 && gap_left == 0) begin
        burst_left = rnd_range(1, 12);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : rnd_range(1, 20);
      end
      drive_now = 1'b0;
      if (gap_left > 0) gap_left--;
      else drive_now = (pending_cmds.size() > 0);
      start <= drive_now;
      if (drive_now) begin
        next_cmd = pending_cmds[0];
        in_mode <= next_cmd.mode;
        in_index <= next_cmd.index;
        in_a_x <= next_cmd.a[0]; in_a_y <= next_cmd.a[1]; in_a_z <= next_cmd.a[2];
        in_b_x <= next_cmd.b[0]; in_b_y <= next_cmd.b[1]; in_b_z <= next_cmd.b[2];
        in_normal_axis <= next_cmd.axis;
        in_collides <= next_cmd.coll;
        in_limit <= next_cmd.limit;
        in_exclude <= next_cmd.excl;
      end
    end
  end

  // Monitor: every result beat against the oldest expected hit.
  hit_rec_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = expected_hits.pop_front();
        if (out_hit !== want.hit) report_mismatch("hit", out_hit, want.hit);
        if (out_hit_index !== want.idx) report_mismatch("hit_index", out_hit_index, want.idx);
        if (out_hit_k !== want.k) report_mismatch("hit_k", out_hit_k, want.k);
        if (out_hit_x !== want.pt[0]) report_mismatch("hit_x", out_hit_x, want.pt[0]);
        if (out_hit_y !== want.pt[1]) report_mismatch("hit_y", out_hit_y, want.pt[1]);
        if (out_hit_z !== want.pt[2]) report_mismatch("hit_z", out_hit_z, want.pt[2]);
        queries_done++;
        if (want.hit) hits_seen++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_scales(logic [30:0] tile, logic [30:0] height);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CfgTileScale; cfg_wdata <= tile;
    @(posedge clk);
    cfg_index <= CfgHeightScale; cfg_wdata <= height;
    @(posedge clk);
    cfg_we <= 1'b0;
    tile_scale_m = longint'(tile);
    height_scale_m = longint'(height);
  endtask

  task automatic drain();
    wait (pending_cmds.size() == 0 && expected_hits.size() == 0);
    repeat (4) @(posedge clk);
    wait (!busy);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [30:0] tile_set [4];
    logic [30:0] height_set [4];
    for (int e = 0; e < Entries; e++) tbl_valid[e] = 1'b0;
    tile_set = '{31'd65536, 31'd1, 31'h7fffffff, 31'd0};
    height_set = '{31'd65536, 31'h7fffffff, 31'd1, 31'd0};
    tile_set[3] = 31'($urandom_range(16384, 262144));
    height_set[3] = 31'($urandom_range(16384, 262144));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) write_scales(tile_set[ph], height_set[ph]);
      if (ph == 0) begin
        // Directed: basic hit, exclusion, negative k, small direction, axis three,
        // non-colliding, limit zero and max.
        pending_cmds.push_back(ray_cmd(0, 0, 0, 65536, 0, 0, 31'h7fffffff, 64));
        pending_cmds.push_back(rect_cmd(0, 2, 0, 0, 0, 3, 3, 0, 1));
        pending_cmds.push_back(rect_cmd(63, 1, 0, 0, 0, -3, 4, 0, 1));
        pending_cmds.push_back(rect_cmd(5, 3, -8192, 8191, -16384, 16383, 2, 3, 1));
        pending_cmds.push_back(rect_cmd(7, 0, 0, 1, 2, 2, 0, 2, 0));
        pending_cmds.push_back(ray_cmd(0, 32768, 32768, 65536, 0, 0, 31'h7fffffff, 64));
        pending_cmds.push_back(ray_cmd(0, -32768, 32768, 65536, 0, 0, 31'h7fffffff, 64));
        pending_cmds.push_back(ray_cmd(0, 32768, 32768, 65536, 0, 0, 31'h7fffffff, 0));
        pending_cmds.push_back(ray_cmd(0, -32768, 32768, 65536, 0, 0, 31'h7fffffff, 63));
        pending_cmds.push_back(ray_cmd(0, 32768, 32768, -65536, 0, 0, 31'h7fffffff, 64));
        pending_cmds.push_back(ray_cmd(0, 32768, 32768, 65, 0, 0, 31'h7fffffff, 64));
        pending_cmds.push_back(ray_cmd(0, 32768, 32768, 66, 0, 0, 31'h7fffffff, 64));
        pending_cmds.push_back(ray_cmd(0, 32768, 32768, 65536, 0, 0, 31'd0, 127));
        pending_cmds.push_back(ray_cmd(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                       32'h80000000, 32'h7fffffff, 32'h80000000,
                                       31'h7fffffff, 64));
        pending_cmds.push_back(blank_cmd(2'd3));
        pending_cmds.push_back(blank_cmd(ModeClear));
        pending_cmds.push_back(ray_cmd(0, 32768, 32768, 65536, 0, 0, 31'h7fffffff, 64));
      end
      for (int i = 0; i < 250; i++) pending_cmds.push_back(random_cmd());
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d queries (%0d hits) over four scale settings with random pacing.",
             queries_done, hits_seen);
    if (errors == 0 && expected_hits.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_hits.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== ray_rectangle_closest_hit_core.f =====
+incdir+rtl
rtl/rrc_pkg.sv
rtl/rrc_div.sv
rtl/ray_rectangle_closest_hit_core.sv
tb/ray_rectangle_closest_hit_core_tb.sv
